// ===== hw/rtl/ppu_pkg.sv =====
package ppu_pkg;

    localparam int POOL_SIZE = 64;
    localparam int IDX_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W     = IDX_W + 1;
    localparam int SLOT_W    = 6;
    localparam int POS_W     = 24;
    localparam int DT_W      = 16;
    localparam int LIFE_W    = 17;
    localparam int GREY_W    = 9;
    localparam int DRAW_W    = 7;
    localparam int PROD_W    = POS_W + DT_W + 1;
    localparam int IN_TDATA_W  = 176;
    localparam int OUT_TDATA_W = 88;

    localparam logic [LIFE_W-1:0] LIFE_ONE = LIFE_W'(65536);
    localparam logic [DRAW_W-1:0] DRAW_MAX = DRAW_W'(99);
    localparam logic [POS_W-1:0]  DIV10_MAGIC = 24'hCCCCCD;

    typedef struct packed {
        logic [LIFE_W-1:0]       life;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] vel_x;
        logic signed [POS_W-1:0] vel_y;
        logic [GREY_W-1:0]       grey;
        logic [LIFE_W-1:0]       opac;
    } part_t;

    localparam int PART_W = $bits(part_t);

    typedef struct packed {
        logic             in_ready;
        logic             load_in;
        logic             spawn_wr;
        logic             tick_rd;
        logic             tick_cap;
        logic             tick_wr;
        logic             last;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic alive_at_idx;
        logic out_free;
    } stat_t;

    // saturate a 26-bit signed sum to 24 bits
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
        logic signed [POS_W+1:0] hi;
        logic signed [POS_W+1:0] lo;
        hi = (POS_W+2)'(8388607);
        lo = -(POS_W+2)'(8388608);
        if (v > hi) begin
            sat_pos = POS_W'(hi);
        end else if (v < lo) begin
            sat_pos = POS_W'(lo);
        end else begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

    // ((d-50)*256)/10 truncated toward zero, d in 0..99
    function automatic logic signed [11:0] jitter_of(input logic [DRAW_W-1:0] d);
        logic [DRAW_W-1:0] m;
        logic [14:0]       mag;
        logic [28:0]       q;
        logic [11:0]       r;
        if (d >= DRAW_W'(50)) begin
            m = d - DRAW_W'(50);
        end else begin
            m = DRAW_W'(50) - d;
        end
        mag = {m, 8'b0};
        q   = 29'(mag) * 29'(6554);
        r   = q[27:16];
        jitter_of = (d >= DRAW_W'(50)) ? $signed(r) : -$signed(r);
    endfunction

    // 128 + d*256/100
    function automatic logic [GREY_W-1:0] shade_of(input logic [DRAW_W-1:0] d);
        logic [14:0] x;
        logic [30:0] q;
        x = {d, 8'b0};
        q = 31'(x) * 31'(41944);
        shade_of = GREY_W'(128) + GREY_W'(q[30:22]);
    endfunction

endpackage

// ===== hw/rtl/ppu_ram.sv =====
module ppu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ===== hw/rtl/ppu_ctrl.sv =====
module ppu_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           in_tick,
    input  ppu_pkg::stat_t stat,
    output ppu_pkg::cmd_t  cmd
);
    import ppu_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_SPAWN_WR = 6'b000100,
        ST_TICK_RD  = 6'b001000,
        ST_TICK_CAP = 6'b010000,
        ST_TICK_WR  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [IDX_W-1:0]  idx_inc;
    logic              idx_top;

    assign idx_top = (idx_reg == IDX_W'(POOL_SIZE - 1));
    assign idx_inc = idx_top ? '0 : idx_reg + IDX_W'(1);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.load_in  = in_valid;
                if (in_valid) begin
                    cnt_next = '0;
                    if (in_tick) begin
                        idx_next   = '0;
                        state_next = ST_TICK_RD;
                    end else begin
                        idx_next   = start_reg;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!stat.alive_at_idx) begin
                    state_next = ST_SPAWN_WR;
                end else if (cnt_reg == CNT_W'(POOL_SIZE - 1)) begin
                    // pool full
                    idx_next   = '0;
                    state_next = ST_SPAWN_WR;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    idx_next = idx_inc;
                end
            end
            ST_SPAWN_WR: begin
                cmd.last = 1'b1;
                if (stat.out_free) begin
                    cmd.spawn_wr = 1'b1;
                    start_next   = idx_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK_RD: begin
                cmd.tick_rd = 1'b1;
                state_next  = ST_TICK_CAP;
            end
            ST_TICK_CAP: begin
                cmd.tick_cap = 1'b1;
                state_next   = ST_TICK_WR;
            end
            ST_TICK_WR: begin
                cmd.last = idx_top;
                if (stat.out_free) begin
                    cmd.tick_wr = 1'b1;
                    idx_next    = idx_inc;
                    state_next  = idx_top ? ST_IDLE : ST_TICK_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            start_reg <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
        end
    end
endmodule

// ===== hw/rtl/ppu_dp.sv =====
module ppu_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ppu_pkg::cmd_t                      cmd,
    output ppu_pkg::stat_t                     stat,
    input  logic [ppu_pkg::IN_TDATA_W-1:0]     in_data,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [ppu_pkg::OUT_TDATA_W-1:0]    out_data,
    output logic                               out_last
);
    import ppu_pkg::*;

    // latched request
    logic [DT_W-1:0]         dt_reg;
    logic signed [POS_W-1:0] spx_in_reg, spy_in_reg, svx_in_reg, svy_in_reg;
    logic signed [POS_W-1:0] sox_in_reg, soy_in_reg;
    logic [DRAW_W-1:0]       jd_in_reg, sd_in_reg;

    // spawn precompute
    logic signed [POS_W-1:0] sp_px_reg, sp_py_reg;
    logic [2*POS_W-1:0]      sp_vxp_reg, sp_vyp_reg;
    logic                    sp_vxn_reg, sp_vyn_reg;
    logic [GREY_W-1:0]       sp_grey_reg;

    // tick capture
    logic [LIFE_W-1:0]        tk_life_reg, tk_opac_reg;
    logic                     tk_alive_reg;
    logic signed [PROD_W-1:0] tk_mx_reg, tk_my_reg;
    part_t                    tk_old_reg;

    logic [POOL_SIZE-1:0]     alive_reg, alive_next;
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic                     out_last_reg;

    part_t                    rd_word, wr_word;
    logic                     wr_en;

    assign stat.alive_at_idx = alive_reg[cmd.idx];
    assign stat.out_free     = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            dt_reg     <= in_data[15:0];
            spx_in_reg <= in_data[39:16];
            spy_in_reg <= in_data[63:40];
            svx_in_reg <= in_data[87:64];
            svy_in_reg <= in_data[111:88];
            sox_in_reg <= in_data[135:112];
            soy_in_reg <= in_data[159:136];
            jd_in_reg  <= in_data[166:160];
            sd_in_reg  <= in_data[173:167];
        end
    end

    // spawn arithmetic, refreshed every cycle from the latched request
    logic [DRAW_W-1:0]        jd_sat, sd_sat;
    logic signed [11:0]       jit;
    logic [POS_W-1:0]         vx_mag, vy_mag;

    always_comb begin
        jd_sat = (jd_in_reg > DRAW_MAX) ? DRAW_MAX : jd_in_reg;
        sd_sat = (sd_in_reg > DRAW_MAX) ? DRAW_MAX : sd_in_reg;
        jit    = jitter_of(jd_sat);
        vx_mag = svx_in_reg[POS_W-1] ? POS_W'(-svx_in_reg) : svx_in_reg;
        vy_mag = svy_in_reg[POS_W-1] ? POS_W'(-svy_in_reg) : svy_in_reg;
    end

    always_ff @(posedge aclk) begin
        sp_px_reg   <= sat_pos((POS_W+2)'(spx_in_reg) + (POS_W+2)'(jit)
                               + (POS_W+2)'(sox_in_reg));
        sp_py_reg   <= sat_pos((POS_W+2)'(spy_in_reg) + (POS_W+2)'(jit)
                               + (POS_W+2)'(soy_in_reg));
        sp_vxp_reg  <= (2*POS_W)'(vx_mag) * (2*POS_W)'(DIV10_MAGIC);
        sp_vyp_reg  <= (2*POS_W)'(vy_mag) * (2*POS_W)'(DIV10_MAGIC);
        sp_vxn_reg  <= svx_in_reg[POS_W-1];
        sp_vyn_reg  <= svy_in_reg[POS_W-1];
        sp_grey_reg <= shade_of(sd_sat);
    end

    // tick capture stage
    logic [LIFE_W-1:0] life_in;
    logic [DT_W+2:0]   fade;

    always_comb begin
        life_in = alive_reg[cmd.idx] ? rd_word.life : '0;
        fade    = ((DT_W+3)'(dt_reg) + ((DT_W+3)'(dt_reg) << 2)) >> 1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_cap) begin
            tk_life_reg  <= (life_in > LIFE_W'(dt_reg)) ? life_in - LIFE_W'(dt_reg) : '0;
            tk_alive_reg <= (life_in > LIFE_W'(dt_reg));
            tk_opac_reg  <= ((DT_W+3)'(rd_word.opac) > fade)
                            ? rd_word.opac - LIFE_W'(fade) : '0;
            tk_mx_reg    <= PROD_W'(rd_word.vel_x) * $signed({1'b0, dt_reg});
            tk_my_reg    <= PROD_W'(rd_word.vel_y) * $signed({1'b0, dt_reg});
            tk_old_reg   <= rd_word;
        end
    end

    // write-back word
    logic signed [PROD_W-17:0] dx, dy;
    logic [20:0]               qx, qy;

    always_comb begin
        dx = tk_mx_reg[PROD_W-1:16];
        dy = tk_my_reg[PROD_W-1:16];
        qx = sp_vxp_reg[47:27];
        qy = sp_vyp_reg[47:27];
        wr_word = '0;
        wr_en   = 1'b0;
        alive_next = alive_reg;
        if (cmd.spawn_wr) begin
            wr_en         = 1'b1;
            wr_word.life  = LIFE_ONE;
            wr_word.pos_x = sp_px_reg;
            wr_word.pos_y = sp_py_reg;
            wr_word.vel_x = sp_vxn_reg ? -POS_W'(qx) : POS_W'(qx);
            wr_word.vel_y = sp_vyn_reg ? -POS_W'(qy) : POS_W'(qy);
            wr_word.grey  = sp_grey_reg;
            wr_word.opac  = LIFE_ONE;
            alive_next[cmd.idx] = 1'b1;
        end else if (cmd.tick_wr) begin
            wr_en         = tk_alive_reg;
            wr_word.life  = tk_life_reg;
            wr_word.pos_x = sat_pos((POS_W+2)'(tk_old_reg.pos_x) - (POS_W+2)'(dx));
            wr_word.pos_y = sat_pos((POS_W+2)'(tk_old_reg.pos_y) - (POS_W+2)'(dy));
            wr_word.vel_x = tk_old_reg.vel_x;
            wr_word.vel_y = tk_old_reg.vel_y;
            wr_word.grey  = tk_old_reg.grey;
            wr_word.opac  = tk_opac_reg;
            alive_next[cmd.idx] = tk_alive_reg;
        end
    end

    ppu_ram #(
        .WIDTH (PART_W),
        .DEPTH (POOL_SIZE)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (cmd.idx),
        .wr_data (wr_word),
        .rd_en   (cmd.tick_rd),
        .rd_addr (cmd.idx),
        .rd_data (rd_word)
    );

    // result register
    logic                   load_out;
    logic                   out_live;
    logic [OUT_TDATA_W-1:0] out_word;

    always_comb begin
        load_out = cmd.spawn_wr || cmd.tick_wr;
        out_live = cmd.spawn_wr || tk_alive_reg;
        out_word = '0;
        out_word[5:0] = SLOT_W'(cmd.idx);
        if (out_live) begin
            out_word[6]     = 1'b1;
            out_word[30:7]  = wr_word.pos_x;
            out_word[54:31] = wr_word.pos_y;
            out_word[63:55] = wr_word.grey;
            out_word[80:64] = wr_word.opac;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            alive_reg <= alive_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= out_word;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;
endmodule

// ===== hw/rtl/particle_pool_update.sv =====
// channel | group | contents
// in      | s_    | one request: tuser opcode (0 spawn, 1 tick), tdata source fields
// out     | m_    | one slot report per result, tlast on the final one of a request
//
// a spawn takes an accept step, then a probe of each slot in the circular search
// (1..64 probed) and a write
// a tick takes an accept step, then for each slot a registered ram read, a multiply
// and a write back
// aresetn is synchronous; reset kills every particle through per-slot alive flags
// a stalled m_tready holds the sequencer at the write-back step of the current slot
// the result register lets a new request be taken while the last result waits
module particle_pool_update (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tick_dt, source_pos_x, source_pos_y, source_vel_x, source_vel_y,
    // spawn_offset_x, spawn_offset_y, jitter_draw, shade_draw, zero pad
    input  logic [ppu_pkg::IN_TDATA_W-1:0]      s_tdata,
    // opcode
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // slot, alive, part_pos_x, part_pos_y, shade, alpha, zero pad
    output logic [ppu_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import ppu_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer
    ppu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_tick  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // particle store, arithmetic and result register
    ppu_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    assign s_tready = cmd.in_ready;
endmodule

// ===== hw/rtl/ppu_checker.sv =====
module ppu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ppu_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import ppu_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_dead_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[6] |-> m_tdata[80:7] == '0)
        else $error("dead slot reported nonzero fields");
endmodule

bind particle_pool_update ppu_checker u_ppu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
